// ===== rtl/tat_pkg.sv =====
// Shared types and constants for the timed action table.
`default_nettype none
package tat_pkg;
   localparam int TableDepthDefault = 32;
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;
   typedef enum logic [2:0] {
      KIND_EXPIRED = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_REMOVE  = 3'd2,
      KIND_QUERY   = 3'd3,
      KIND_DONE    = 3'd4
   } kind_type;
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_PLAYER  = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  target_id;
      logic [2:0]  action_type;
      logic        target_is_player;
      logic [15:0] delay;
      logic        can_interrupt;
      logic [15:0] payload_tag;
      logic [31:0] now_time;
      logic        interrupt_only;
   } req_type;
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  target_id_res;
      logic [2:0]  action_type_res;
      logic [15:0] payload_tag_res;
      logic        found;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
   typedef struct packed {
      logic [7:0]  target;
      logic [2:0]  act_type;
      logic [31:0] deadline;
      logic        interruptible;
      logic [15:0] payload;
   } slot_type;
endpackage
`default_nettype wire

// ===== rtl/tat_if.sv =====
// Valid/ready channel interface carrying one request or response.
`default_nettype none
interface tat_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/timed_action_table.sv =====
// Timed action table: ordered store of pending actions with add, tick, remove, query.
//
//  channel | dir | payload  | handshake
//  req     | in  | req_type | valid/ready, taken when both high
//  rsp     | out | rsp_type | valid/ready, taken when both high
//
// One request at a time. Add writes the new slot, then answers; tick, remove and
// query scan the table once through the single memory read port, reading and then
// examining each slot in turn; a query stops at its first match. Compaction writes
// survivors back in place during the same scan.
// Reset empties the table at once (fill count); slots need no clearing.
// A stalled response holds the scan until it is taken.
`default_nettype none
module timed_action_table
   import tat_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   tat_if.sink       req,
   tat_if.source     rsp
);
   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXAM, ST_SEND, ST_FINAL
   } state_type;

   slot_type mem [TABLE_DEPTH];
   slot_type rd_ff;
   state_type state_ff;
   req_type   cur_ff;
   logic [CntW-1:0] count_ff, rd_idx_ff, wr_idx_ff;
   logic any_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [1:0] status_ff;

   logic [32:0] dl_sum;
   logic [31:0] dl_sat;
   logic        mem_we;
   logic [IdxW-1:0] mem_wa;
   slot_type    mem_wd;
   logic        hit_tick, hit_rem, hit_qry;

   assign dl_sum = {1'b0, cur_ff.now_time} + {17'd0, cur_ff.delay};
   assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
   assign hit_tick = rd_ff.deadline <= cur_ff.now_time;
   assign hit_rem  = (rd_ff.target == cur_ff.target_id) &&
                     (!cur_ff.interrupt_only || rd_ff.interruptible);
   assign hit_qry  = (rd_ff.target == cur_ff.target_id) &&
                     (rd_ff.act_type == cur_ff.action_type);

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Pick the single memory write for this cycle
   always_comb begin
      mem_we = 1'b0;
      mem_wa = wr_idx_ff[IdxW-1:0];
      mem_wd = rd_ff;
      if (state_ff == ST_READ && cur_ff.cmd == CMD_ADD && status_ff == STATUS_OK) begin
         mem_we = 1'b1;
         mem_wa = count_ff[IdxW-1:0];
         mem_wd = '{target: cur_ff.target_id, act_type: cur_ff.action_type,
                    deadline: dl_sat, interruptible: cur_ff.can_interrupt,
                    payload: cur_ff.payload_tag};
      end else if (state_ff == ST_EXAM && !rsp_valid_ff) begin
         if ((cur_ff.cmd == CMD_TICK && !hit_tick) ||
             (cur_ff.cmd == CMD_REMOVE && !hit_rem)) begin
            mem_we = 1'b1;
         end
      end
   end

   // Slot memory: one write, one registered read; hold the read slot while it is examined
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (state_ff == ST_READ) begin
         rd_ff <= mem[rd_idx_ff[IdxW-1:0]];
      end
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         any_ff       <= 1'b0;
         status_ff    <= STATUS_OK;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  cur_ff    <= req.data;
                  rd_idx_ff <= '0;
                  wr_idx_ff <= '0;
                  any_ff    <= 1'b0;
                  if (req.data.action_type < 3'd4 && !req.data.target_is_player) begin
                     status_ff <= STATUS_PLAYER;
                  end else if (count_ff >= CntW'(TABLE_DEPTH)) begin
                     status_ff <= STATUS_FULL;
                  end else begin
                     status_ff <= STATUS_OK;
                  end
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               // Add writes here; scans get the read data in the next cycle
               if (cur_ff.cmd == CMD_ADD) begin
                  if (status_ff == STATUS_OK) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= ST_FINAL;
               end else if (rd_idx_ff >= count_ff || (cur_ff.cmd == CMD_QUERY && any_ff)) begin
                  state_ff <= ST_FINAL;
               end else begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
                  state_ff  <= ST_EXAM;
               end
            end
            ST_EXAM: begin
               // Hold while a previous response waits
               if (!rsp_valid_ff) begin
                  state_ff <= ST_READ;
                  unique case (cur_ff.cmd)
                     CMD_TICK: begin
                        if (hit_tick) begin
                           any_ff       <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= '{kind: KIND_EXPIRED, target_id_res: rd_ff.target,
                                       action_type_res: rd_ff.act_type,
                                       payload_tag_res: rd_ff.payload, found: 1'b0,
                                       status: STATUS_OK, last: 1'b0};
                        end else begin
                           wr_idx_ff <= wr_idx_ff + 1'b1;
                        end
                     end
                     CMD_REMOVE: begin
                        if (hit_rem) begin
                           any_ff <= 1'b1;
                        end else begin
                           wr_idx_ff <= wr_idx_ff + 1'b1;
                        end
                     end
                     default: begin
                        if (hit_qry) begin
                           any_ff <= 1'b1;
                        end
                     end
                  endcase
               end
            end
            ST_FINAL: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.target_id_res   <= cur_ff.target_id;
                  rsp_ff.action_type_res <= cur_ff.action_type;
                  rsp_ff.payload_tag_res <= '0;
                  rsp_ff.last            <= 1'b1;
                  rsp_ff.found           <= (cur_ff.cmd == CMD_ADD) ? 1'b0 : any_ff;
                  rsp_ff.status          <= (cur_ff.cmd == CMD_ADD) ? status_ff : STATUS_OK;
                  unique case (cur_ff.cmd)
                     CMD_ADD:    rsp_ff.kind <= KIND_ADD;
                     CMD_TICK:   rsp_ff.kind <= KIND_DONE;
                     CMD_REMOVE: rsp_ff.kind <= KIND_REMOVE;
                     default:    rsp_ff.kind <= KIND_QUERY;
                  endcase
                  if (cur_ff.cmd == CMD_TICK || cur_ff.cmd == CMD_REMOVE) begin
                     count_ff <= wr_idx_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/tat_checker.sv =====
// Port-level checker for the timed action table, bound into the table module.
`default_nettype none
module tat_checker
   import tat_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   // Response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   // No new request taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted with response pending");
   // A request is never answered in the cycle after it is taken
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too early");
   // Only expired entries are non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.kind == KIND_EXPIRED)
      else $error("non-final response of wrong kind");
endmodule

bind timed_action_table tat_checker u_tat_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
